// ===== rtl/v3alu_pkg.sv =====
// Shared types, constants and the saturation helper for the Q16.16 vector ALU.
// No dependencies.
package v3alu_pkg;

	localparam int W  = 32;
	localparam int F  = 16;
	localparam int XW = 2 * W + 2;
	localparam int QW = W + F;

	typedef logic signed [W-1:0]   word_t;
	typedef logic [W-1:0]          uword_t;
	typedef logic signed [2*W-1:0] prod_t;
	typedef logic signed [XW-1:0]  xw_t;
	typedef word_t [2:0]           vec_t;

	localparam logic [3:0] CMD_ADD       = 4'd0;
	localparam logic [3:0] CMD_SUB       = 4'd1;
	localparam logic [3:0] CMD_SCALE     = 4'd2;
	localparam logic [3:0] CMD_DIVIDE    = 4'd3;
	localparam logic [3:0] CMD_NEGATE    = 4'd4;
	localparam logic [3:0] CMD_DOT       = 4'd5;
	localparam logic [3:0] CMD_CROSS     = 4'd6;
	localparam logic [3:0] CMD_LENGTH    = 4'd7;
	localparam logic [3:0] CMD_NORMALIZE = 4'd8;
	localparam logic [3:0] CMD_REFLECT   = 4'd9;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam word_t W_MAX = {1'b0, {(W-1){1'b1}}};
	localparam word_t W_MIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [3:0] cmd;
		word_t      ax;
		word_t      ay;
		word_t      az;
		word_t      bx;
		word_t      by;
		word_t      bz;
		word_t      scalar_in;
	} req_t;

	typedef struct packed {
		word_t      rx;
		word_t      ry;
		word_t      rz;
		word_t      scalar_out;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		word_t v;
		logic  ovf;
	} sat_t;

	typedef struct packed {
		vec_t       r;
		word_t      sc;
		logic [1:0] st;
	} res_t;

	typedef struct packed {
		logic [3:0] cmd;
		vec_t       a;
		word_t      s;
		res_t       res;
	} pipe_t;

	typedef struct packed {
		logic [3:0] cmd;
		res_t       res;
	} tail_t;

	function automatic sat_t sat_x(input xw_t x);
		sat_t r;
		if (x > xw_t'(W_MAX)) begin
			r.v   = W_MAX;
			r.ovf = 1'b1;
		end else if (x < xw_t'(W_MIN)) begin
			r.v   = W_MIN;
			r.ovf = 1'b1;
		end else begin
			r.v   = x[W-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/v3alu_delay.sv =====
// Fixed-depth delay line that keeps side data in step with the long units.
// Depends on nothing.
module v3alu_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sr_q [DEPTH];

	always_ff @(posedge clk) begin
		sr_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			sr_q[i] <= sr_q[i-1];
		end
	end

	assign q = sr_q[DEPTH-1];

endmodule

// ===== rtl/v3alu_merge.sv =====
// Merge stage: combines lane products into per-op results, the dot sum and
// the squared magnitude. Depends on v3alu_pkg.
module v3alu_merge
	import v3alu_pkg::*;
(
	input  logic         clk,
	input  logic [3:0]   cmd,
	input  word_t        a [3],
	input  word_t        b [3],
	input  prod_t        p1 [3],
	input  prod_t        p2 [3],
	output res_t         res_s2,
	output sat_t         dot_s2,
	output logic [2*W-1:0] sq_s2
);

	sat_t ladd [3];
	sat_t lsub [3];
	sat_t lscl [3];
	sat_t lneg [3];
	sat_t lcrs [3];
	sat_t dot;
	xw_t  dsum;
	res_t res;
	logic [2*W-1:0] sq;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ladd[i] = sat_x(xw_t'(a[i]) + xw_t'(b[i]));
			lsub[i] = sat_x(xw_t'(a[i]) - xw_t'(b[i]));
			lscl[i] = sat_x(xw_t'(p1[i]) >>> F);
			lneg[i] = sat_x(-xw_t'(a[i]));
			lcrs[i] = sat_x((xw_t'(p1[i]) - xw_t'(p2[i])) >>> F);
		end
		dsum = xw_t'(p1[0]) + xw_t'(p1[1]) + xw_t'(p1[2]);
		dot  = sat_x(dsum >>> F);
		sq   = $unsigned(p1[0]) + $unsigned(p1[1]) + $unsigned(p1[2]);

		res = '0;
		unique case (cmd)
			CMD_ADD: begin
				for (int i = 0; i < 3; i++) res.r[i] = ladd[i].v;
				res.st = (ladd[0].ovf | ladd[1].ovf | ladd[2].ovf) ? ST_SAT : ST_OK;
			end
			CMD_SUB: begin
				for (int i = 0; i < 3; i++) res.r[i] = lsub[i].v;
				res.st = (lsub[0].ovf | lsub[1].ovf | lsub[2].ovf) ? ST_SAT : ST_OK;
			end
			CMD_SCALE: begin
				for (int i = 0; i < 3; i++) res.r[i] = lscl[i].v;
				res.st = (lscl[0].ovf | lscl[1].ovf | lscl[2].ovf) ? ST_SAT : ST_OK;
			end
			CMD_NEGATE: begin
				for (int i = 0; i < 3; i++) res.r[i] = lneg[i].v;
				res.st = (lneg[0].ovf | lneg[1].ovf | lneg[2].ovf) ? ST_SAT : ST_OK;
			end
			CMD_CROSS: begin
				for (int i = 0; i < 3; i++) res.r[i] = lcrs[i].v;
				res.st = (lcrs[0].ovf | lcrs[1].ovf | lcrs[2].ovf) ? ST_SAT : ST_OK;
			end
			CMD_DOT: begin
				res.sc = dot.v;
				res.st = dot.ovf ? ST_SAT : ST_OK;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
		dot_s2 <= dot;
		sq_s2  <= sq;
	end

endmodule

// ===== rtl/v3alu_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on v3alu_pkg.
module v3alu_isqrt
	import v3alu_pkg::*;
(
	input  logic           clk,
	input  logic [2*W-1:0] radicand,
	output uword_t         root
);

	localparam int RW = 2 * W;

	logic [RW-1:0] n_i [W];
	logic [RW-1:0] r_i [W];
	logic [RW-1:0] t   [W];
	logic [RW-1:0] n_q [W-1];
	logic [RW-1:0] r_q [W];

	for (genvar k = 0; k < W; k++) begin : g_step
		localparam logic [RW-1:0] BIT = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * k);
		if (k == 0) begin : g_first
			assign n_i[k] = radicand;
			assign r_i[k] = '0;
		end else begin : g_next
			assign n_i[k] = n_q[k-1];
			assign r_i[k] = r_q[k-1];
		end
		assign t[k] = r_i[k] + BIT;
		always_ff @(posedge clk) begin
			if (n_i[k] >= t[k]) begin
				r_q[k] <= (r_i[k] >> 1) + BIT;
			end else begin
				r_q[k] <= r_i[k] >> 1;
			end
		end
		if (k < W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				n_q[k] <= (n_i[k] >= t[k]) ? n_i[k] - t[k] : n_i[k];
			end
		end
	end

	assign root = r_q[W-1][W-1:0];

endmodule

// ===== rtl/v3alu_div.sv =====
// Pipelined signed fixed-point divider for one lane: (num << F) / den,
// truncated toward zero and saturated. Depends on v3alu_pkg.
module v3alu_div
	import v3alu_pkg::*;
(
	input  logic   clk,
	input  logic   num_neg,
	input  uword_t num_mag,
	input  logic   den_neg,
	input  uword_t den_mag,
	output word_t  q,
	output logic   ovf,
	output logic   dz
);

	localparam logic [QW-1:0] LIM_P = {{(F+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [QW-1:0] LIM_N = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

	logic [QW-1:0] num_q [QW+1];
	uword_t        rem_q [QW];
	uword_t        den_q [QW];
	logic          neg_q [QW+1];
	logic          dz_q  [QW+1];
	logic [QW-1:0] nq;
	word_t         q_q;
	logic          ovf_q;
	logic          dzo_q;

	always_ff @(posedge clk) begin
		num_q[0] <= {num_mag, {F{1'b0}}};
		rem_q[0] <= '0;
		den_q[0] <= den_mag;
		neg_q[0] <= num_neg ^ den_neg;
		dz_q[0]  <= (den_mag == '0);
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [W:0] t;
		logic [W:0] diff;
		logic       ge;
		assign t    = {rem_q[k-1], num_q[k-1][QW-1]};
		assign diff = t - {1'b0, den_q[k-1]};
		assign ge   = (t >= {1'b0, den_q[k-1]});
		always_ff @(posedge clk) begin
			num_q[k] <= {num_q[k-1][QW-2:0], ge};
			neg_q[k] <= neg_q[k-1];
			dz_q[k]  <= dz_q[k-1];
		end
		if (k < QW) begin : g_carry
			always_ff @(posedge clk) begin
				rem_q[k] <= ge ? diff[W-1:0] : t[W-1:0];
				den_q[k] <= den_q[k-1];
			end
		end
	end

	assign nq = -num_q[QW];

	always_ff @(posedge clk) begin
		dzo_q <= dz_q[QW];
		if (neg_q[QW]) begin
			ovf_q <= (num_q[QW] > LIM_N);
			q_q   <= (num_q[QW] > LIM_N) ? W_MIN : nq[W-1:0];
		end else begin
			ovf_q <= (num_q[QW] > LIM_P);
			q_q   <= (num_q[QW] > LIM_P) ? W_MAX : num_q[QW][W-1:0];
		end
	end

	assign q   = q_q;
	assign ovf = ovf_q;
	assign dz  = dzo_q;

endmodule

// ===== rtl/vec3_fixed_point_alu.sv =====
// Top level of the three-component Q16.16 vector ALU.
// Depends on v3alu_pkg, v3alu_merge, v3alu_isqrt, v3alu_div, v3alu_delay.
//
// A request is taken on any cycle with start high; busy is always low, so one
// request may be issued every clock. Every operation has the same latency:
// the result appears on result with done high exactly one cycle, in request
// order. The latency is set by the 32-stage square root followed by the 48-step
// lane dividers that normalize needs, while length uses the root alone; all
// other operations are padded to match. The receiver cannot stall, so the
// result must be captured on the cycle done is high.
module vec3_fixed_point_alu
	import v3alu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t result
);

	localparam int SQ_LAT   = W;
	localparam int DA_DEPTH = 2 + SQ_LAT - 4;
	localparam int DC_DEPTH = QW + 2;
	localparam int VLD_LEN  = 2 + SQ_LAT + DC_DEPTH;
	localparam int NEXT [3] = '{1, 2, 0};
	localparam int PREV [3] = '{2, 0, 1};

	word_t a_in [3];
	word_t b_in [3];
	word_t xsel [3];
	word_t ysel [3];

	logic [3:0] cmd_s1, cmd_s2, cmd_s3;
	word_t a_s1 [3], b_s1 [3], a_s2 [3], b_s2 [3], a_s3 [3];
	word_t s_s1, s_s2, s_s3;
	prod_t p1_s1 [3], p2_s1 [3], prod_s3 [3];

	res_t  res_s2, res_s3, res_n;
	sat_t  dot_s2, m;
	logic [2*W-1:0] sq_s2;
	logic  rfl_ovf_s3;
	sat_t  pr [3], rr [3];
	vec_t  a_pk;
	pipe_t pipe_s4, pipe_s34;

	uword_t len_s34;
	res_t   res34;
	tail_t  tail_in, tail_s84;
	uword_t nmag [3];
	uword_t dmag;
	logic   dneg;
	word_t  q [3];
	logic   ovf [3];
	logic   dz [3];

	logic [VLD_LEN-1:0] vld_q;
	logic done_q;
	rsp_t out_n, result_q;

	assign busy = 1'b0;
	assign a_in = '{req.ax, req.ay, req.az};
	assign b_in = '{req.bx, req.by, req.bz};

	// lane multiplier operand selection
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xsel[i] = (req.cmd == CMD_CROSS) ? a_in[NEXT[i]] : a_in[i];
			priority if (req.cmd == CMD_SCALE) begin
				ysel[i] = req.scalar_in;
			end else if (req.cmd == CMD_CROSS) begin
				ysel[i] = b_in[PREV[i]];
			end else if (req.cmd == CMD_LENGTH || req.cmd == CMD_NORMALIZE) begin
				ysel[i] = a_in[i];
			end else begin
				ysel[i] = b_in[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= req.cmd;
		s_s1   <= req.scalar_in;
		for (int i = 0; i < 3; i++) begin
			a_s1[i]  <= a_in[i];
			b_s1[i]  <= b_in[i];
			p1_s1[i] <= prod_t'(xsel[i]) * prod_t'(ysel[i]);
			p2_s1[i] <= prod_t'(a_in[PREV[i]]) * prod_t'(b_in[NEXT[i]]);
		end
	end

	v3alu_merge u_merge (
		.clk    (clk),
		.cmd    (cmd_s1),
		.a      (a_s1),
		.b      (b_s1),
		.p1     (p1_s1),
		.p2     (p2_s1),
		.res_s2 (res_s2),
		.dot_s2 (dot_s2),
		.sq_s2  (sq_s2)
	);

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		s_s2   <= s_s1;
		for (int i = 0; i < 3; i++) begin
			a_s2[i] <= a_s1[i];
			b_s2[i] <= b_s1[i];
		end
	end

	// reflect: m = 2*dot, then b*m
	assign m = sat_x(xw_t'(dot_s2.v) + xw_t'(dot_s2.v));

	always_ff @(posedge clk) begin
		cmd_s3     <= cmd_s2;
		s_s3       <= s_s2;
		res_s3     <= res_s2;
		rfl_ovf_s3 <= dot_s2.ovf | m.ovf;
		for (int i = 0; i < 3; i++) begin
			a_s3[i]    <= a_s2[i];
			prod_s3[i] <= prod_t'(b_s2[i]) * prod_t'(m.v);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pr[i]   = sat_x(xw_t'(prod_s3[i]) >>> F);
			rr[i]   = sat_x(xw_t'(a_s3[i]) - xw_t'(pr[i].v));
			a_pk[i] = a_s3[i];
		end
		if (cmd_s3 == CMD_REFLECT) begin
			res_n = '0;
			for (int i = 0; i < 3; i++) res_n.r[i] = rr[i].v;
			res_n.st = (rfl_ovf_s3 | pr[0].ovf | pr[1].ovf | pr[2].ovf |
				rr[0].ovf | rr[1].ovf | rr[2].ovf) ? ST_SAT : ST_OK;
		end else begin
			res_n = res_s3;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s4 <= '{cmd: cmd_s3, a: a_pk, s: s_s3, res: res_n};
	end

	v3alu_delay #(.WIDTH($bits(pipe_t)), .DEPTH(DA_DEPTH)) u_dly_a (
		.clk (clk),
		.d   (pipe_s4),
		.q   (pipe_s34)
	);

	v3alu_isqrt u_sqrt (
		.clk      (clk),
		.radicand (sq_s2),
		.root     (len_s34)
	);

	always_comb begin
		res34 = pipe_s34.res;
		if (pipe_s34.cmd == CMD_LENGTH) begin
			res34 = '0;
			if (len_s34[W-1]) begin
				res34.sc = W_MAX;
				res34.st = ST_SAT;
			end else begin
				res34.sc = word_t'(len_s34);
			end
		end
		if (pipe_s34.cmd == CMD_DIVIDE) begin
			dneg = pipe_s34.s[W-1];
			dmag = pipe_s34.s[W-1] ? uword_t'(-pipe_s34.s) : uword_t'(pipe_s34.s);
		end else begin
			dneg = 1'b0;
			dmag = len_s34;
		end
		for (int i = 0; i < 3; i++) begin
			nmag[i] = pipe_s34.a[i][W-1] ? uword_t'(-pipe_s34.a[i])
				: uword_t'(pipe_s34.a[i]);
		end
		tail_in = '{cmd: pipe_s34.cmd, res: res34};
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane_div
		v3alu_div u_div (
			.clk     (clk),
			.num_neg (pipe_s34.a[i][W-1]),
			.num_mag (nmag[i]),
			.den_neg (dneg),
			.den_mag (dmag),
			.q       (q[i]),
			.ovf     (ovf[i]),
			.dz      (dz[i])
		);
	end

	v3alu_delay #(.WIDTH($bits(tail_t)), .DEPTH(DC_DEPTH)) u_dly_c (
		.clk (clk),
		.d   (tail_in),
		.q   (tail_s84)
	);

	always_comb begin
		out_n = '0;
		if (tail_s84.cmd == CMD_DIVIDE || tail_s84.cmd == CMD_NORMALIZE) begin
			if (dz[0] | dz[1] | dz[2]) begin
				out_n.status = ST_DIVZ;
			end else begin
				out_n.rx     = q[0];
				out_n.ry     = q[1];
				out_n.rz     = q[2];
				out_n.status = (ovf[0] | ovf[1] | ovf[2]) ? ST_SAT : ST_OK;
			end
		end else begin
			out_n.rx         = tail_s84.res.r[0];
			out_n.ry         = tail_s84.res.r[1];
			out_n.rz         = tail_s84.res.r[2];
			out_n.scalar_out = tail_s84.res.sc;
			out_n.status     = tail_s84.res.st;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= out_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[VLD_LEN-2:0], start & ~busy};
			done_q <= vld_q[VLD_LEN-1];
		end
	end

	assign done   = done_q;
	assign result = result_q;

	ast_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_DIVZ ||
			result.status == ST_SAT))
		else $error("result status outside its codes");

	ast_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_DIVZ) |->
			(result.rx == '0 && result.ry == '0 && result.rz == '0 &&
			result.scalar_out == '0))
		else $error("zero-divisor result carries non-zero data");

	ast_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[VLD_LEN-1] |=> done)
		else $error("request left the pipe without a done strobe");

endmodule
